>>> hdl/ps2_set1_scancode_event_queue_assert.svh
// ----------------------------------------------------------------------------
// PS/2 Set 1 event queue assertion macros
// Shared concurrent assertion forms for the event queue RTL.
// ----------------------------------------------------------------------------
`ifndef PS2_SET1_SCANCODE_EVENT_QUEUE_ASSERT_SVH
`define PS2_SET1_SCANCODE_EVENT_QUEUE_ASSERT_SVH

// same-cycle implication
`define PS2S1_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ps2s1 assertion failed");

// next-cycle implication
`define PS2S1_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ps2s1 assertion failed");

`endif

>>> hdl/ps2s1_pkg.sv
// ----------------------------------------------------------------------------
// ps2s1_pkg
// Types, codes and scancode tables for the PS/2 Set 1 event queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ps2s1_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 64;
   localparam int CMD_FIFO_DEPTH      = 2;

   localparam logic [5:0] KC_LCTRL  = 6'd5;
   localparam logic [5:0] KC_LSHIFT = 6'd6;
   localparam logic [5:0] KC_RSHIFT = 6'd7;
   localparam logic [5:0] KC_LALT   = 6'd8;
   localparam logic [5:0] KC_CAPS   = 6'd10;

   localparam logic MODE_SCAN = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef enum logic [2:0] {
      ST_QUEUED   = 3'd0,
      ST_MODIFIER = 3'd1,
      ST_DROPPED  = 3'd2,
      ST_POPPED   = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_MOD  = 2'd1,
      OP_POP  = 2'd2
   } op_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] scan_byte;
   } req_type;

   typedef struct packed {
      logic       caps_flag;
      logic       alt_flag;
      logic       ctrl_flag;
      logic       shift_flag;
      logic       key_pressed;
      logic [6:0] ascii_char;
      logic [5:0] key_code;
   } event_type;

   typedef struct packed {
      logic [2:0] status;
      logic [5:0] key_code;
      logic [6:0] ascii_char;
      logic       key_pressed;
      logic       shift_flag;
      logic       ctrl_flag;
      logic       alt_flag;
      logic       caps_flag;
      logic       queue_not_empty;
   } rsp_type;

   typedef struct packed {
      op_type    op;
      event_type evt;
   } cmd_type;

   function automatic logic [5:0] key_code_lookup(input logic [6:0] sc);
      logic [5:0] kc;
      unique case (sc)
         7'h01:   kc = 6'd1;
         7'h0E:   kc = 6'd2;
         7'h0F:   kc = 6'd3;
         7'h1C:   kc = 6'd4;
         7'h1D:   kc = 6'd5;
         7'h2A:   kc = 6'd6;
         7'h36:   kc = 6'd7;
         7'h38:   kc = 6'd8;
         7'h39:   kc = 6'd9;
         7'h3A:   kc = 6'd10;
         7'h3B:   kc = 6'd11;
         7'h3C:   kc = 6'd12;
         7'h3D:   kc = 6'd13;
         7'h3E:   kc = 6'd14;
         7'h3F:   kc = 6'd15;
         7'h40:   kc = 6'd16;
         7'h41:   kc = 6'd17;
         7'h42:   kc = 6'd18;
         7'h43:   kc = 6'd19;
         7'h44:   kc = 6'd20;
         7'h45:   kc = 6'd21;
         7'h46:   kc = 6'd22;
         7'h47:   kc = 6'd23;
         7'h48:   kc = 6'd24;
         7'h49:   kc = 6'd25;
         7'h4B:   kc = 6'd26;
         7'h4D:   kc = 6'd27;
         7'h4F:   kc = 6'd28;
         7'h50:   kc = 6'd29;
         7'h51:   kc = 6'd30;
         7'h52:   kc = 6'd31;
         7'h53:   kc = 6'd32;
         7'h57:   kc = 6'd33;
         7'h58:   kc = 6'd34;
         default: kc = 6'd0;
      endcase
      return kc;
   endfunction

   function automatic logic [6:0] lower_char(input logic [6:0] sc);
      logic [6:0] ch;
      unique case (sc)
         7'h02: ch = 7'h31;  7'h03: ch = 7'h32;  7'h04: ch = 7'h33;
         7'h05: ch = 7'h34;  7'h06: ch = 7'h35;  7'h07: ch = 7'h36;
         7'h08: ch = 7'h37;  7'h09: ch = 7'h38;  7'h0A: ch = 7'h39;
         7'h0B: ch = 7'h30;  7'h0C: ch = 7'h2D;  7'h0D: ch = 7'h3D;
         7'h0E: ch = 7'h08;  7'h0F: ch = 7'h09;
         7'h10: ch = 7'h71;  7'h11: ch = 7'h77;  7'h12: ch = 7'h65;
         7'h13: ch = 7'h72;  7'h14: ch = 7'h74;  7'h15: ch = 7'h79;
         7'h16: ch = 7'h75;  7'h17: ch = 7'h69;  7'h18: ch = 7'h6F;
         7'h19: ch = 7'h70;  7'h1A: ch = 7'h5B;  7'h1B: ch = 7'h5D;
         7'h1E: ch = 7'h61;  7'h1F: ch = 7'h73;  7'h20: ch = 7'h64;
         7'h21: ch = 7'h66;  7'h22: ch = 7'h67;  7'h23: ch = 7'h68;
         7'h24: ch = 7'h6A;  7'h25: ch = 7'h6B;  7'h26: ch = 7'h6C;
         7'h27: ch = 7'h3B;  7'h28: ch = 7'h27;  7'h29: ch = 7'h60;
         7'h2B: ch = 7'h5C;
         7'h2C: ch = 7'h7A;  7'h2D: ch = 7'h78;  7'h2E: ch = 7'h63;
         7'h2F: ch = 7'h76;  7'h30: ch = 7'h62;  7'h31: ch = 7'h6E;
         7'h32: ch = 7'h6D;  7'h33: ch = 7'h2C;  7'h34: ch = 7'h2E;
         7'h35: ch = 7'h2F;  7'h37: ch = 7'h2A;  7'h39: ch = 7'h20;
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [6:0] upper_char(input logic [6:0] sc);
      logic [6:0] ch;
      unique case (sc)
         7'h02: ch = 7'h21;  7'h03: ch = 7'h40;  7'h04: ch = 7'h23;
         7'h05: ch = 7'h24;  7'h06: ch = 7'h25;  7'h07: ch = 7'h5E;
         7'h08: ch = 7'h26;  7'h09: ch = 7'h2A;  7'h0A: ch = 7'h28;
         7'h0B: ch = 7'h29;  7'h0C: ch = 7'h5F;  7'h0D: ch = 7'h2B;
         7'h0E: ch = 7'h08;  7'h0F: ch = 7'h09;
         7'h10: ch = 7'h51;  7'h11: ch = 7'h57;  7'h12: ch = 7'h45;
         7'h13: ch = 7'h52;  7'h14: ch = 7'h54;  7'h15: ch = 7'h59;
         7'h16: ch = 7'h55;  7'h17: ch = 7'h49;  7'h18: ch = 7'h4F;
         7'h19: ch = 7'h50;  7'h1A: ch = 7'h7B;  7'h1B: ch = 7'h7D;
         7'h1C: ch = 7'h0A;
         7'h1E: ch = 7'h41;  7'h1F: ch = 7'h53;  7'h20: ch = 7'h44;
         7'h21: ch = 7'h46;  7'h22: ch = 7'h47;  7'h23: ch = 7'h48;
         7'h24: ch = 7'h4A;  7'h25: ch = 7'h4B;  7'h26: ch = 7'h4C;
         7'h27: ch = 7'h3A;  7'h28: ch = 7'h22;  7'h29: ch = 7'h7E;
         7'h2B: ch = 7'h7C;
         7'h2C: ch = 7'h5A;  7'h2D: ch = 7'h58;  7'h2E: ch = 7'h43;
         7'h2F: ch = 7'h56;  7'h30: ch = 7'h42;  7'h31: ch = 7'h4E;
         7'h32: ch = 7'h4D;  7'h33: ch = 7'h3C;  7'h34: ch = 7'h3E;
         7'h35: ch = 7'h3F;  7'h37: ch = 7'h2A;  7'h39: ch = 7'h20;
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

>>> hdl/ps2_set1_scancode_event_queue.sv
// PS/2 Set 1 scancode event queue. Takes one request transfer per cycle while
// req_stall is low and returns exactly one response transfer per request, in
// request order. A scancode request updates shift/ctrl/alt/caps state or queues
// a key event; a read request pops the oldest event. The ring holds
// QUEUE_DEPTH - 1 events and drops new ones when full. A request passes through
// a two-entry command FIFO between decode and the ring, then the response
// register; these keep the input taking requests while a response waits. The
// event store needs no clearing after reset.
// ----------------------------------------------------------------------------
// ps2_set1_scancode_event_queue
// Top level: decode front, command FIFO and event ring back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ps2_set1_scancode_event_queue #(
   parameter int QUEUE_DEPTH = ps2s1_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  ps2s1_pkg::req_type  req,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output ps2s1_pkg::rsp_type  rsp
);
   import ps2s1_pkg::*;

   cmd_type front_cmd, back_cmd;
   logic    front_valid, front_ready;
   logic    back_valid, back_ready;

   ps2s1_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd       (front_cmd)
   );

   ps2s1_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_cmd)
   );

   ps2s1_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (back_valid),
      .cmd_ready (back_ready),
      .cmd       (back_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire

>>> hdl/ps2s1_front.sv
// ----------------------------------------------------------------------------
// ps2s1_front
// Takes request transfers, decodes scancodes, tracks modifier state and
// issues push / modifier / pop commands to the command FIFO.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ps2s1_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  ps2s1_pkg::req_type  req,
   output logic                cmd_valid,
   input  wire                 cmd_ready,
   output ps2s1_pkg::cmd_type  cmd
);
   import ps2s1_pkg::*;

   logic       shift_ff, shift_in;
   logic       ctrl_ff, ctrl_in;
   logic       alt_ff, alt_in;
   logic       caps_ff, caps_in;
   logic       accept;
   logic [6:0] sc;
   logic       pressed;
   logic [5:0] kc;
   logic       is_shift, is_ctrl, is_alt, is_caps;

   assign req_stall = !cmd_ready;
   assign cmd_valid = req_valid;
   assign accept    = req_valid && cmd_ready;

   assign sc       = req.scan_byte[6:0];
   assign pressed  = !req.scan_byte[7];
   assign kc       = key_code_lookup(sc);
   assign is_shift = (kc == KC_LSHIFT) || (kc == KC_RSHIFT);
   assign is_ctrl  = (kc == KC_LCTRL);
   assign is_alt   = (kc == KC_LALT);
   assign is_caps  = (kc == KC_CAPS);

   always_comb begin
      cmd.evt.key_code    = kc;
      cmd.evt.ascii_char  = (shift_ff ^ caps_ff) ? upper_char(sc) : lower_char(sc);
      cmd.evt.key_pressed = pressed;
      cmd.evt.shift_flag  = shift_ff;
      cmd.evt.ctrl_flag   = ctrl_ff;
      cmd.evt.alt_flag    = alt_ff;
      cmd.evt.caps_flag   = caps_ff;
      if (req.mode == MODE_READ) begin
         cmd.op = OP_POP;
      end else if (is_shift || is_ctrl || is_alt || is_caps) begin
         cmd.op = OP_MOD;
      end else begin
         cmd.op = OP_PUSH;
      end
   end

   always_comb begin
      shift_in = shift_ff;
      ctrl_in  = ctrl_ff;
      alt_in   = alt_ff;
      caps_in  = caps_ff;
      if (accept && (req.mode == MODE_SCAN)) begin
         if (is_shift) begin
            shift_in = pressed;
         end
         if (is_ctrl) begin
            ctrl_in = pressed;
         end
         if (is_alt) begin
            alt_in = pressed;
         end
         if (is_caps && pressed) begin
            caps_in = !caps_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         ctrl_ff  <= 1'b0;
         alt_ff   <= 1'b0;
         caps_ff  <= 1'b0;
      end else begin
         shift_ff <= shift_in;
         ctrl_ff  <= ctrl_in;
         alt_ff   <= alt_in;
         caps_ff  <= caps_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/ps2s1_cmd_fifo.sv
// ----------------------------------------------------------------------------
// ps2s1_cmd_fifo
// Two-entry command FIFO decoupling the decode front from the queue back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ps2s1_cmd_fifo (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push_valid,
   output logic                push_ready,
   input  ps2s1_pkg::cmd_type  push_data,
   output logic                pop_valid,
   input  wire                 pop_ready,
   output ps2s1_pkg::cmd_type  pop_data
);
   import ps2s1_pkg::*;

   localparam int IDX_W = $clog2(CMD_FIFO_DEPTH);
   localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

   cmd_type            slot_ff [CMD_FIFO_DEPTH];
   logic [IDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(CMD_FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_idx_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_idx_in = (wr_idx_ff == IDX_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_idx_ff + IDX_W'(1);
      end
      if (do_pop) begin
         rd_idx_in = (rd_idx_ff == IDX_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_idx_ff + IDX_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_idx_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> hdl/ps2s1_back.sv
// ----------------------------------------------------------------------------
// ps2s1_back
// Event ring queue: pushes, pops and drops events, registers the response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ps2_set1_scancode_event_queue_assert.svh"

module ps2s1_back #(
   parameter int QUEUE_DEPTH = ps2s1_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 cmd_valid,
   output logic                cmd_ready,
   input  ps2s1_pkg::cmd_type  cmd,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output ps2s1_pkg::rsp_type  rsp
);
   import ps2s1_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   event_type          store [QUEUE_DEPTH];
   event_type          rd_data_ff;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]   wr_next, rd_next;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   logic               not_empty_ff, not_empty_in;
   logic               fire, empty, full, mem_we, mem_re;

   assign cmd_ready = !rsp_valid_ff || !rsp_stall;
   assign fire      = cmd_valid && cmd_ready;
   assign empty     = (wr_ptr_ff == rd_ptr_ff);
   assign wr_next   = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
   assign rd_next   = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
   assign full      = (wr_next == rd_ptr_ff);

   always_comb begin
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      status_in    = status_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (fire) begin
         rsp_valid_in = 1'b1;
         unique case (cmd.op)
            OP_POP: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  status_in = ST_POPPED;
                  mem_re    = 1'b1;
                  rd_ptr_in = rd_next;
               end
            end
            OP_PUSH: begin
               if (full) begin
                  status_in = ST_DROPPED;
               end else begin
                  status_in = ST_QUEUED;
                  mem_we    = 1'b1;
                  wr_ptr_in = wr_next;
               end
            end
            OP_MOD: begin
               status_in = ST_MODIFIER;
            end
            default: begin
               status_in = ST_MODIFIER;
            end
         endcase
      end
      not_empty_in = fire ? (wr_ptr_in != rd_ptr_in) : not_empty_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      not_empty_ff <= not_empty_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[wr_ptr_ff] <= cmd.evt;
      end
      if (mem_re) begin
         rd_data_ff <= store[rd_ptr_ff];
      end
   end

   always_comb begin
      rsp                 = '0;
      rsp.status          = status_ff;
      rsp.queue_not_empty = not_empty_ff;
      if (status_ff == ST_POPPED) begin
         rsp.key_code    = rd_data_ff.key_code;
         rsp.ascii_char  = rd_data_ff.ascii_char;
         rsp.key_pressed = rd_data_ff.key_pressed;
         rsp.shift_flag  = rd_data_ff.shift_flag;
         rsp.ctrl_flag   = rd_data_ff.ctrl_flag;
         rsp.alt_flag    = rd_data_ff.alt_flag;
         rsp.caps_flag   = rd_data_ff.caps_flag;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `PS2S1_ASSERT_NEXT(a_fire_gives_rsp, clock, reset, fire, rsp_valid_ff)
   `PS2S1_ASSERT_NEXT(a_empty_pop, clock, reset, fire && (cmd.op == OP_POP) && empty,
                      (status_ff == ST_EMPTY) && $stable(rd_ptr_ff))
   `PS2S1_ASSERT_NEXT(a_full_drop, clock, reset, fire && (cmd.op == OP_PUSH) && full,
                      (status_ff == ST_DROPPED) && $stable(wr_ptr_ff))
   `PS2S1_ASSERT_SAME(a_no_overrun, clock, reset, mem_we, wr_next != rd_ptr_ff)

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives Set 1 scancodes and read requests into the keyboard event queue and
// checks every response against an in-bench decoder and event ring, with
// random sender gaps, receiver stalls and a long receiver hold-off.
// ----------------------------------------------------------------------------

module tb_top;
   import ps2s1_pkg::*;

   localparam int RING_SLOTS   = QUEUE_DEPTH_DEFAULT - 1;
   localparam int HOLD_CYCLES  = 300;
   localparam int LIMIT_CYCLES = 200000;

   localparam logic [6:0] KEY_SCANS [34] = '{
      7'h01, 7'h0E, 7'h0F, 7'h1C, 7'h1D, 7'h2A, 7'h36, 7'h38, 7'h39, 7'h3A,
      7'h3B, 7'h3C, 7'h3D, 7'h3E, 7'h3F, 7'h40, 7'h41, 7'h42, 7'h43, 7'h44,
      7'h45, 7'h46, 7'h47, 7'h48, 7'h49, 7'h4B, 7'h4D, 7'h4F, 7'h50, 7'h51,
      7'h52, 7'h53, 7'h57, 7'h58};
   localparam logic [6:0] MOD_SCANS [5] = '{7'h2A, 7'h36, 7'h1D, 7'h38, 7'h3A};
   localparam logic [7:0] OPENING_SCANS [17] = '{
      8'h00, 8'hFF, 8'h1C, 8'h3A, 8'hBA, 8'h1C, 8'h2A, 8'h1E, 8'h1D, 8'h38,
      8'h58, 8'hAA, 8'h36, 8'h35, 8'h9D, 8'hB8, 8'h3A};

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   // decoder tables and state
   logic [5:0] kc_tab [128];
   logic [7:0] lo_tab [128];
   logic [7:0] up_tab [128];
   logic       shift_dn, ctrl_dn, alt_dn, caps_on;
   event_type  queued_events [$];

   req_type    keystrokes_todo [$];
   rsp_type    rsp_owed [$];
   int         send_idle_pct = 0;
   int         rcv_stall_pct = 0;
   logic       hold_req = 1'b0;
   int         hold_cnt = 0;
   int         cycle_cnt = 0;
   int         mismatch_cnt = 0;
   int         rsp_seen = 0;

   ps2_set1_scancode_event_queue uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == LIMIT_CYCLES) begin
         $display("ps2_set1_scancode_event_queue test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_req) hold_cnt <= hold_cnt + 1;
      else hold_cnt <= 0;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t rsp %0d: %s", $realtime, rsp_seen, msg);
      mismatch_cnt++;
   endtask

   task automatic load_row(input int base, input string lo, input string up);
      for (int i = 0; i < lo.len(); i++) begin
         lo_tab[base + i] = lo[i];
         up_tab[base + i] = up[i];
      end
   endtask

   function automatic rsp_type decode_keystroke(input req_type r);
      rsp_type    o;
      event_type  ev;
      logic [6:0] sc;
      logic       pressed;
      logic [5:0] kc;
      o = '0;
      sc = r.scan_byte[6:0];
      pressed = !r.scan_byte[7];
      kc = kc_tab[sc];
      if (r.mode == MODE_READ) begin
         if (queued_events.size() == 0) begin
            o.status = ST_EMPTY;
         end else begin
            ev = queued_events.pop_front();
            o.status      = ST_POPPED;
            o.key_code    = ev.key_code;
            o.ascii_char  = ev.ascii_char;
            o.key_pressed = ev.key_pressed;
            o.shift_flag  = ev.shift_flag;
            o.ctrl_flag   = ev.ctrl_flag;
            o.alt_flag    = ev.alt_flag;
            o.caps_flag   = ev.caps_flag;
         end
      end else if (kc == KC_LSHIFT || kc == KC_RSHIFT) begin
         shift_dn = pressed;
         o.status = ST_MODIFIER;
      end else if (kc == KC_LCTRL) begin
         ctrl_dn = pressed;
         o.status = ST_MODIFIER;
      end else if (kc == KC_LALT) begin
         alt_dn = pressed;
         o.status = ST_MODIFIER;
      end else if (kc == KC_CAPS) begin
         if (pressed) caps_on = !caps_on;
         o.status = ST_MODIFIER;
      end else begin
         ev.key_code    = kc;
         ev.ascii_char  = (shift_dn ^ caps_on) ? up_tab[sc][6:0] : lo_tab[sc][6:0];
         ev.key_pressed = pressed;
         ev.shift_flag  = shift_dn;
         ev.ctrl_flag   = ctrl_dn;
         ev.alt_flag    = alt_dn;
         ev.caps_flag   = caps_on;
         if (queued_events.size() >= RING_SLOTS) begin
            o.status = ST_DROPPED;
         end else begin
            queued_events.push_back(ev);
            o.status = ST_QUEUED;
         end
      end
      o.queue_not_empty = (queued_events.size() != 0);
      return o;
   endfunction

   task automatic check_rsp(input rsp_type got, input rsp_type want);
      if (got.status !== want.status)
         report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.key_code !== want.key_code)
         report_mismatch($sformatf("key_code %0d, want %0d", got.key_code, want.key_code));
      if (got.ascii_char !== want.ascii_char)
         report_mismatch($sformatf("ascii_char %h, want %h", got.ascii_char, want.ascii_char));
      if (got.key_pressed !== want.key_pressed)
         report_mismatch($sformatf("key_pressed %b, want %b", got.key_pressed,
                                   want.key_pressed));
      if (got.shift_flag !== want.shift_flag)
         report_mismatch($sformatf("shift_flag %b, want %b", got.shift_flag, want.shift_flag));
      if (got.ctrl_flag !== want.ctrl_flag)
         report_mismatch($sformatf("ctrl_flag %b, want %b", got.ctrl_flag, want.ctrl_flag));
      if (got.alt_flag !== want.alt_flag)
         report_mismatch($sformatf("alt_flag %b, want %b", got.alt_flag, want.alt_flag));
      if (got.caps_flag !== want.caps_flag)
         report_mismatch($sformatf("caps_flag %b, want %b", got.caps_flag, want.caps_flag));
      if (got.queue_not_empty !== want.queue_not_empty)
         report_mismatch($sformatf("queue_not_empty %b, want %b", got.queue_not_empty,
                                   want.queue_not_empty));
   endtask

   // driver: predicts on each accepted transfer, holds payload while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) rsp_owed.push_back(decode_keystroke(req));
         if (keystrokes_todo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req       <= keystrokes_todo.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_owed.size() == 0) report_mismatch("response with none outstanding");
            else check_rsp(rsp, rsp_owed.pop_front());
            rsp_seen++;
         end
         rsp_stall <= hold_req || ($urandom_range(99) < rcv_stall_pct);
      end
   end

   task automatic add_item(input logic mode, input logic [7:0] scan);
      req_type r;
      r.mode = mode;
      r.scan_byte = scan;
      keystrokes_todo.push_back(r);
   endtask

   task automatic add_random(input int read_pct);
      logic [7:0] b;
      b = $urandom;
      if ($urandom_range(99) < read_pct) begin
         add_item(MODE_READ, b);
      end else begin
         case ($urandom_range(9))
            0: ;
            1, 2: b = {$urandom_range(99) < 40, MOD_SCANS[$urandom_range(4)]};
            default: begin
               b[6:0] = ($urandom_range(3) == 0) ? KEY_SCANS[$urandom_range(33)]
                                                  : 7'($urandom_range(1, 'h39));
               b[7] = ($urandom_range(99) < 35);
            end
         endcase
         add_item(MODE_SCAN, b);
      end
   endtask

   task automatic wait_drained();
      while (keystrokes_todo.size() != 0 || req_valid || rsp_owed.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_phase(input int count, input int read_pct,
                            input int send_pct, input int stall_pct);
      @(negedge clock);
      send_idle_pct = send_pct;
      rcv_stall_pct = stall_pct;
      repeat (count) add_random(read_pct);
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < 128; i++) begin
         kc_tab[i] = '0;
         lo_tab[i] = '0;
         up_tab[i] = '0;
      end
      for (int i = 0; i < 34; i++) kc_tab[KEY_SCANS[i]] = 6'(i + 1);
      load_row('h02, "1234567890-=", "!@#$%^&*()_+");
      load_row('h10, "qwertyuiop[]", "QWERTYUIOP{}");
      load_row('h1E, "asdfghjkl;'\140", "ASDFGHJKL:\"~");
      load_row('h2C, "zxcvbnm,./", "ZXCVBNM<>?");
      load_row('h0E, "\010\t", "\010\t");
      load_row('h2B, "\\", "|");
      load_row('h37, "*", "*");
      load_row('h39, " ", " ");
      up_tab['h1C] = 8'h0A;  // enter is only printable in the upper table
      shift_dn = 1'b0;
      ctrl_dn  = 1'b0;
      alt_dn   = 1'b0;
      caps_on  = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // opening sequence: empty read, field extremes, modifiers, caps, enter
      @(negedge clock);
      add_item(MODE_READ, 8'h00);
      foreach (OPENING_SCANS[i]) add_item(MODE_SCAN, OPENING_SCANS[i]);
      repeat (8) add_item(MODE_READ, 8'hFF);
      wait_drained();

      run_phase(280, 45, 0, 0);
      run_phase(280, 20, 52, 0);
      run_phase(280, 70, 0, 52);
      run_phase(200, 45, 8, 8);

      // long receiver hold-off with the sender still offering transfers
      @(negedge clock);
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      hold_req = 1'b1;
      repeat (120) add_random(20);
      while (hold_cnt < HOLD_CYCLES) @(negedge clock);
      hold_req = 1'b0;
      wait_drained();
      run_phase(80, 90, 0, 0);

      repeat (10) @(negedge clock);
      if (mismatch_cnt == 0 && rsp_owed.size() == 0)
         $display("ps2_set1_scancode_event_queue test passed");
      else
         $display("ps2_set1_scancode_event_queue test failed");
      $finish;
   end

endmodule
